// ===== rtl/core/bmp_rle_index_decoder_top_assert.svh =====
// ----------------------------------------------------------------------------
// bmp_rle_index_decoder_top_assert.svh
// Assertion macros used by the decoder checker.
// ----------------------------------------------------------------------------
`ifndef BMP_RLE_INDEX_DECODER_TOP_ASSERT_SVH
`define BMP_RLE_INDEX_DECODER_TOP_ASSERT_SVH

// same-cycle implication
`define BRID_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BRID_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/brid_pkg.sv =====
// ----------------------------------------------------------------------------
// brid_pkg
// Types, constants and helpers for the RLE8/RLE4 bitmap index decoder.
// ----------------------------------------------------------------------------
package brid_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    localparam int DIM_W   = 13;
    localparam int COORD_W = 13;
    localparam int OUT_C_W = 12;
    localparam int BYTE_W  = 8;
    localparam int IDX_W   = 2;
    localparam int TDATA_W = 48;

    localparam logic [COORD_W-1:0] COORD_TOP = '1;
    localparam logic [BYTE_W-1:0]  NIB_MASK  = 8'h0F;

    localparam logic [IDX_W-1:0] REG_MODE   = 2'd0;
    localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd2;

    localparam logic [0:0] EV_SPAN = 1'b0;
    localparam logic [0:0] EV_EOB  = 1'b1;

    typedef enum logic [6:0] {
        PH_FIRST  = 7'b0000001,
        PH_SECOND = 7'b0000010,
        PH_DX     = 7'b0000100,
        PH_DY     = 7'b0001000,
        PH_ABS    = 7'b0010000,
        PH_PAD    = 7'b0100000,
        PH_DONE   = 7'b1000000
    } t_phase;

    typedef struct packed {
        logic             nib;
        logic [DIM_W-1:0] eff_w;
        logic [DIM_W-1:0] eff_h;
        logic             restart;
    } t_cfg;

    typedef struct packed {
        logic               valid;
        logic               kind;
        logic [OUT_C_W-1:0] row;
        logic [OUT_C_W-1:0] col;
        logic [BYTE_W-1:0]  len;
        logic [BYTE_W-1:0]  first;
        logic [BYTE_W-1:0]  second;
    } t_result;

    function automatic logic [DIM_W-1:0] clamp_dim(
        input logic [DIM_W-1:0] v,
        input logic [DIM_W-1:0] lim
    );
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > lim) begin
            r = lim;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/brid_cfg.sv =====
// ----------------------------------------------------------------------------
// brid_cfg
// Configuration registers, clamped dimensions and restart pulse.
// ----------------------------------------------------------------------------
module brid_cfg #(
    parameter int MAX_WIDTH  = brid_pkg::MAX_WIDTH,
    parameter int MAX_HEIGHT = brid_pkg::MAX_HEIGHT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [brid_pkg::IDX_W-1:0]        i_cfg_index,
    input  logic [brid_pkg::DIM_W-1:0]        i_cfg_data,
    output brid_pkg::t_cfg                    o_cfg
);

    localparam int LIM_W_I = (MAX_WIDTH < 4096) ? ((MAX_WIDTH < 1) ? 1 : MAX_WIDTH) : 4096;
    localparam int LIM_H_I = (MAX_HEIGHT < 4096) ? ((MAX_HEIGHT < 1) ? 1 : MAX_HEIGHT) : 4096;
    localparam logic [brid_pkg::DIM_W-1:0] LIM_W = brid_pkg::DIM_W'(LIM_W_I);
    localparam logic [brid_pkg::DIM_W-1:0] LIM_H = brid_pkg::DIM_W'(LIM_H_I);

    logic                       r_nib,     n_nib;
    logic [brid_pkg::DIM_W-1:0] r_eff_w,   n_eff_w;
    logic [brid_pkg::DIM_W-1:0] r_eff_h,   n_eff_h;
    logic                       r_restart, n_restart;

    always_comb begin
        n_nib     = r_nib;
        n_eff_w   = r_eff_w;
        n_eff_h   = r_eff_h;
        n_restart = 1'b0;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                brid_pkg::REG_MODE: begin
                    n_nib     = i_cfg_data[0];
                    n_restart = 1'b1;
                end
                brid_pkg::REG_WIDTH: begin
                    n_eff_w   = brid_pkg::clamp_dim(i_cfg_data, LIM_W);
                    n_restart = 1'b1;
                end
                brid_pkg::REG_HEIGHT: begin
                    n_eff_h   = brid_pkg::clamp_dim(i_cfg_data, LIM_H);
                    n_restart = 1'b1;
                end
                default: begin
                    n_restart = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nib     <= 1'b0;
            r_eff_w   <= brid_pkg::DIM_W'(1);
            r_eff_h   <= brid_pkg::DIM_W'(1);
            r_restart <= 1'b0;
        end else begin
            r_nib     <= n_nib;
            r_eff_w   <= n_eff_w;
            r_eff_h   <= n_eff_h;
            r_restart <= n_restart;
        end
    end

    assign o_cfg = '{nib: r_nib, eff_w: r_eff_w, eff_h: r_eff_h, restart: r_restart};

endmodule

// ===== rtl/core/brid_in.sv =====
// ----------------------------------------------------------------------------
// brid_in
// Input register stage for compressed bytes, with stall control.
// ----------------------------------------------------------------------------
module brid_in (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [brid_pkg::BYTE_W-1:0]  i_byte,
    output logic                         o_ready,
    input  logic                         i_restart,
    input  logic                         i_out_free,
    output logic                         o_step,
    output logic [brid_pkg::BYTE_W-1:0]  o_byte
);

    logic                        r_valid, n_valid;
    logic [brid_pkg::BYTE_W-1:0] r_byte;
    logic                        w_accept;

    assign o_step   = r_valid && i_out_free;
    assign o_ready  = !i_restart && (!r_valid || o_step);
    assign w_accept = i_valid && o_ready;

    always_comb begin
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (o_step) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_byte <= i_byte;
        end
    end

    assign o_byte = r_byte;

endmodule

// ===== rtl/core/brid_parse.sv =====
// ----------------------------------------------------------------------------
// brid_parse
// Pair parser: phase machine, cursor tracking and span clipping.
// ----------------------------------------------------------------------------
module brid_parse (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  brid_pkg::t_cfg               i_cfg,
    input  logic                         i_step,
    input  logic [brid_pkg::BYTE_W-1:0]  i_byte,
    output brid_pkg::t_result            o_result
);

    localparam int BW = brid_pkg::BYTE_W;
    localparam int CW = brid_pkg::COORD_W;

    brid_pkg::t_phase r_phase, n_phase;
    logic [BW-1:0]    r_held,  n_held;
    logic [BW-1:0]    r_rem,   n_rem;
    logic             r_pad,   n_pad;
    logic [CW-1:0]    r_col,   n_col;
    logic [CW-1:0]    r_row,   n_row;

    logic          w_span_en;
    logic [BW-1:0] w_span_n;
    logic [BW-1:0] w_first;
    logic [BW-1:0] w_second;
    logic          w_eob;
    logic          w_right_en;
    logic [BW-1:0] w_right_n;
    logic          w_down_en;
    logic [BW-1:0] w_down_n;
    logic          w_col_clr;
    logic [BW-1:0] w_abs_n;
    logic [BW:0]   w_b_inc;
    logic [CW:0]   w_col_sum;
    logic [CW-1:0] w_col_mv;
    logic [CW-1:0] w_row_mv;
    logic [CW-1:0] w_avail;
    logic [BW-1:0] w_len;
    logic          w_hit;
    logic [BW-1:0] w_hi;
    logic [BW-1:0] w_lo;

    assign w_hi    = i_byte >> 4;
    assign w_lo    = i_byte & brid_pkg::NIB_MASK;
    assign w_b_inc = {1'b0, i_byte} + (BW+1)'(1);
    assign w_abs_n = !i_cfg.nib ? BW'(1) : ((r_rem < BW'(2)) ? r_rem : BW'(2));

    always_comb begin
        n_phase    = r_phase;
        n_held     = r_held;
        n_rem      = r_rem;
        n_pad      = r_pad;
        w_span_en  = 1'b0;
        w_span_n   = r_held;
        w_first    = i_cfg.nib ? w_hi : i_byte;
        w_second   = i_cfg.nib ? w_lo : i_byte;
        w_eob      = 1'b0;
        w_right_en = 1'b0;
        w_right_n  = i_byte;
        w_down_en  = 1'b0;
        w_down_n   = i_byte;
        w_col_clr  = 1'b0;
        unique case (r_phase)
            brid_pkg::PH_FIRST: begin
                n_held  = i_byte;
                n_phase = brid_pkg::PH_SECOND;
            end
            brid_pkg::PH_SECOND: begin
                n_phase = brid_pkg::PH_FIRST;
                if (r_held != '0) begin
                    w_span_en  = 1'b1;
                    w_right_en = 1'b1;
                    w_right_n  = r_held;
                end else if (i_byte == BW'(0)) begin
                    w_down_en = 1'b1;
                    w_down_n  = BW'(1);
                    w_col_clr = 1'b1;
                end else if (i_byte == BW'(1)) begin
                    n_phase = brid_pkg::PH_DONE;
                    w_eob   = 1'b1;
                end else if (i_byte == BW'(2)) begin
                    n_phase = brid_pkg::PH_DX;
                end else begin
                    n_rem   = i_byte;
                    n_pad   = i_cfg.nib ? w_b_inc[1] : i_byte[0];
                    n_phase = brid_pkg::PH_ABS;
                end
            end
            brid_pkg::PH_DX: begin
                w_right_en = 1'b1;
                n_phase    = brid_pkg::PH_DY;
            end
            brid_pkg::PH_DY: begin
                w_down_en = 1'b1;
                n_phase   = brid_pkg::PH_FIRST;
            end
            brid_pkg::PH_ABS: begin
                w_span_en  = 1'b1;
                w_span_n   = w_abs_n;
                w_right_en = 1'b1;
                w_right_n  = w_abs_n;
                n_rem      = r_rem - w_abs_n;
                if (n_rem == '0) begin
                    n_phase = r_pad ? brid_pkg::PH_PAD : brid_pkg::PH_FIRST;
                end
            end
            brid_pkg::PH_PAD: begin
                n_pad   = 1'b0;
                n_phase = brid_pkg::PH_FIRST;
            end
            brid_pkg::PH_DONE: begin
                n_phase = brid_pkg::PH_DONE;
            end
            default: begin
                n_phase = brid_pkg::PH_FIRST;
            end
        endcase
    end

    // saturating cursor moves
    assign w_col_sum = {1'b0, r_col} + (CW+1)'(w_right_n);
    assign w_col_mv  = w_col_sum[CW] ? brid_pkg::COORD_TOP : w_col_sum[CW-1:0];
    assign w_row_mv  = ((r_row == brid_pkg::COORD_TOP) || (CW'(w_down_n) > r_row))
                       ? brid_pkg::COORD_TOP : (r_row - CW'(w_down_n));

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (w_col_clr) begin
            n_col = '0;
        end else if (w_right_en) begin
            n_col = w_col_mv;
        end
        if (w_down_en) begin
            n_row = w_row_mv;
        end
    end

    // clipping against the image
    assign w_avail = i_cfg.eff_w - r_col;
    assign w_len   = (w_avail > CW'(w_span_n)) ? w_span_n : w_avail[BW-1:0];
    assign w_hit   = w_span_en && (w_span_n != '0) && (r_row < i_cfg.eff_h)
                     && (r_col < i_cfg.eff_w);

    always_comb begin
        o_result = '0;
        if (i_step && w_eob) begin
            o_result.valid = 1'b1;
            o_result.kind  = brid_pkg::EV_EOB;
        end else if (i_step && w_hit) begin
            o_result.valid  = 1'b1;
            o_result.kind   = brid_pkg::EV_SPAN;
            o_result.row    = r_row[brid_pkg::OUT_C_W-1:0];
            o_result.col    = r_col[brid_pkg::OUT_C_W-1:0];
            o_result.len    = w_len;
            o_result.first  = w_first;
            o_result.second = w_second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= brid_pkg::PH_FIRST;
            r_held  <= '0;
            r_rem   <= '0;
            r_pad   <= 1'b0;
            r_col   <= '0;
            r_row   <= '0;
        end else if (i_cfg.restart) begin
            r_phase <= brid_pkg::PH_FIRST;
            r_held  <= '0;
            r_rem   <= '0;
            r_pad   <= 1'b0;
            r_col   <= '0;
            r_row   <= i_cfg.eff_h - CW'(1);
        end else if (i_step) begin
            r_phase <= n_phase;
            r_held  <= n_held;
            r_rem   <= n_rem;
            r_pad   <= n_pad;
            r_col   <= n_col;
            r_row   <= n_row;
        end
    end

endmodule

// ===== rtl/core/brid_out.sv =====
// ----------------------------------------------------------------------------
// brid_out
// Result register holding one span or end-of-bitmap transfer.
// ----------------------------------------------------------------------------
module brid_out (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  brid_pkg::t_result             i_result,
    output logic                          o_free,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [brid_pkg::TDATA_W-1:0]  o_tdata,
    output logic                          o_tuser
);

    logic                          r_valid, n_valid;
    logic [brid_pkg::TDATA_W-1:0]  r_tdata;
    logic                          r_tuser;

    assign o_free = !r_valid || i_ready;

    always_comb begin
        if (i_result.valid) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_result.valid) begin
            r_tdata <= {i_result.second, i_result.first, i_result.len,
                        i_result.col, i_result.row};
            r_tuser <= i_result.kind;
        end
    end

    assign o_valid = r_valid;
    assign o_tdata = r_tdata;
    assign o_tuser = r_tuser;

endmodule

// ===== rtl/core/bmp_rle_index_decoder_top.sv =====
// ----------------------------------------------------------------------------
// bmp_rle_index_decoder_top
// RLE8/RLE4 bitmap stream decoder producing clipped palette index spans.
// ----------------------------------------------------------------------------
//  channel   direction  width  contents
//  s_axis    in         8      tdata: stream_byte
//  m_axis    out        48+1   tdata: row, column, length, first, second
//                              tuser: event_kind
//  cfg       in         2+13   index, data (mode, width, height)
//
//  One byte per cycle while no result stalls and no restart is pending; a
//  result is registered through the input register, then the result register.
//  Synchronous active-low reset; decoding restarts at the bottom row.
//  A mode, width or height write restarts the parser; input is held off meanwhile.
//  A stalled result holds the input stage; bytes keep flowing otherwise.
// ----------------------------------------------------------------------------
module bmp_rle_index_decoder_top #(
    parameter int MAX_WIDTH  = brid_pkg::MAX_WIDTH,
    parameter int MAX_HEIGHT = brid_pkg::MAX_HEIGHT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [brid_pkg::IDX_W-1:0]    i_cfg_index,
    input  logic [brid_pkg::DIM_W-1:0]    i_cfg_data,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [brid_pkg::BYTE_W-1:0]   s_axis_tdata,   // [7:0] stream_byte
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [11:0] row_index, [23:12] start_column, [31:24] span_length,
    // [39:32] first_index, [47:40] second_index
    output logic [brid_pkg::TDATA_W-1:0]  m_axis_tdata,
    output logic                          m_axis_tuser    // [0] event_kind
);

    brid_pkg::t_cfg              w_cfg;
    brid_pkg::t_result           w_result;
    logic                        w_step;
    logic                        w_out_free;
    logic [brid_pkg::BYTE_W-1:0] w_byte;

    brid_cfg #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    brid_in u_in (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .i_byte     (s_axis_tdata),
        .o_ready    (s_axis_tready),
        .i_restart  (w_cfg.restart),
        .i_out_free (w_out_free),
        .o_step     (w_step),
        .o_byte     (w_byte)
    );

    brid_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_step   (w_step),
        .i_byte   (w_byte),
        .o_result (w_result)
    );

    brid_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_result (w_result),
        .o_free   (w_out_free),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tuser  (m_axis_tuser)
    );

endmodule

// ===== rtl/core/brid_checker.sv =====
// ----------------------------------------------------------------------------
// brid_checker
// Port-level checks on the decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "bmp_rle_index_decoder_top_assert.svh"

module brid_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_cfg_we,
    input logic [brid_pkg::IDX_W-1:0]    i_cfg_index,
    input logic [brid_pkg::DIM_W-1:0]    i_cfg_data,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic [brid_pkg::BYTE_W-1:0]   s_axis_tdata,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [brid_pkg::TDATA_W-1:0]  m_axis_tdata,
    input logic                          m_axis_tuser
);

    `BRID_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result transfer changed")
    `BRID_ASSERT_IMP(a_eob_zero, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tuser == brid_pkg::EV_EOB), m_axis_tdata == '0, "end of bitmap carries nonzero data")
    `BRID_ASSERT_IMP(a_span_len, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tuser == brid_pkg::EV_SPAN), m_axis_tdata[31:24] != 8'd0, "empty span emitted")
    `BRID_ASSERT_NXT(a_rst_quiet, i_clk, 1'b1, !i_rst_n, !m_axis_tvalid, "result valid after reset")
    `BRID_ASSERT_NXT(a_restart_hold, i_clk, i_rst_n, i_cfg_we && ((i_cfg_index == brid_pkg::REG_MODE) || (i_cfg_index == brid_pkg::REG_WIDTH) || (i_cfg_index == brid_pkg::REG_HEIGHT)), !s_axis_tready, "input taken during restart")

endmodule

bind bmp_rle_index_decoder_top brid_checker u_brid_checker (.*);
